>>> sv/lpm_pkg.sv
// shared types, status codes and the prefix mask helper for the lpm router
package lpm_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ST_ADDED        = 3'd0,
        ST_FORWARDED    = 3'd1,
        ST_DROP_TTL     = 3'd2,
        ST_DROP_NOROUTE = 3'd3,
        ST_FULL         = 3'd4
    } status_t;

    // item kinds
    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned LEN_W  = 6;
    localparam int unsigned PORT_W = 3;
    localparam int unsigned TTL_W  = 8;
    localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

    // input word
    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] net_prefix;
        logic [LEN_W-1:0]  mask_len;
        logic              has_next_hop;
        logic [ADDR_W-1:0] next_hop_addr;
        logic [PORT_W-1:0] egress_port;
        logic [ADDR_W-1:0] dest_addr;
        logic [TTL_W-1:0]  ttl_in;
    } request_t;

    // result word
    typedef struct packed {
        status_t           status;
        logic [PORT_W-1:0] out_port;
        logic [ADDR_W-1:0] hop_addr;
        logic [TTL_W-1:0]  ttl_out;
    } result_t;

    // one stored route
    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  length;
        logic              hop_valid;
        logic [ADDR_W-1:0] hop;
        logic [PORT_W-1:0] port;
    } route_t;

    // query state handed from cell to cell
    typedef struct packed {
        logic              active;
        logic [ADDR_W-1:0] dest;
        logic [TTL_W-1:0]  ttl;
        logic              found;
        logic [LEN_W-1:0]  longest;
        logic [PORT_W-1:0] port;
        logic              hop_valid;
        logic [ADDR_W-1:0] hop;
    } carry_t;

    // high-order mask of len bits, len already saturated to 32
    function automatic logic [ADDR_W-1:0] mask_of(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] m;
        if (len == '0)
            m = '0;
        else
            m = {ADDR_W{1'b1}} << (MAX_LEN - len);
        return m;
    endfunction

endpackage

>>> sv/lpm_cell.sv
// one route cell: holds a route and refines the passing query's best match
module lpm_cell
    import lpm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  route_t wr_route,
    input  logic   enable,
    input  carry_t carry_in,
    output carry_t carry_out
);

    route_t route_reg;
    carry_t carry_reg;
    carry_t carry_next;

    logic [ADDR_W-1:0] mask;
    logic              match;

    // route storage, written once when this cell is the next free slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            route_reg <= wr_route;
        end
    end

    // compare against the stored route; equal length lets the later cell win
    always_comb
    begin
        mask  = mask_of(route_reg.length);
        match = enable
              && ((carry_in.dest & mask) == (route_reg.prefix & mask))
              && (route_reg.length >= carry_in.longest);
        carry_next = carry_in;
        if (carry_in.active && match)
        begin
            carry_next.found     = 1'b1;
            carry_next.longest   = route_reg.length;
            carry_next.port      = route_reg.port;
            carry_next.hop_valid = route_reg.hop_valid;
            carry_next.hop       = route_reg.hop;
        end
    end

    // hand the query to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
        end
        else
        begin
            carry_reg <= carry_next;
        end
    end

    assign carry_out = carry_reg;

endmodule

>>> sv/longest_prefix_match_router.sv
// top level of the ipv4 longest prefix match router
// An add-route word or a datagram whose ttl is 0 or 1 is answered in the cycle after
// it is accepted. A datagram lookup walks the chain of TABLE_DEPTH route cells, each
// of which registers the query, and is answered from the result register after the
// last cell; busy stays high for that walk, so one lookup is in flight at a time. Each
// result appears on result for exactly one cycle with done high and must be taken
// then: there is no way to stall it. Routes are appended in order until TABLE_DEPTH
// are held, then further adds answer table full. No clearing is needed after reset.
module longest_prefix_match_router
    import lpm_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16,
    parameter int unsigned PORT_COUNT  = 8
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     done,
    output result_t  result
);

    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [6:0] PORT_LIMIT = 7'(PORT_COUNT);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    result_t       result_reg;
    result_t       result_next;

    logic   accept;
    logic   do_add;
    logic   do_lookup;
    route_t new_route;
    carry_t chain [0:TABLE_DEPTH];
    carry_t tail;

    assign accept    = start && !busy_reg;
    assign do_add    = accept && (request.kind == KIND_ADD) && (count_reg != DEPTH_C);
    assign do_lookup = accept && (request.kind == KIND_LOOKUP) && (request.ttl_in > 8'd1);

    // route to append, length saturated to 32
    always_comb
    begin
        new_route.prefix    = request.net_prefix;
        new_route.length    = (request.mask_len > MAX_LEN) ? MAX_LEN
                                                            : request.mask_len;
        new_route.hop_valid = request.has_next_hop;
        new_route.hop       = request.next_hop_addr;
        new_route.port      = request.egress_port;
    end

    // query injected into the head of the chain
    always_comb
    begin
        chain[0]           = '0;
        chain[0].active    = do_lookup;
        chain[0].dest      = request.dest_addr;
        chain[0].ttl       = request.ttl_in;
    end

    // chain of route cells
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        lpm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr_en    (do_add && (count_reg == CW'(i))),
            .wr_route (new_route),
            .enable   (CW'(i) < count_reg),
            .carry_in (chain[i]),
            .carry_out(chain[i+1])
        );
    end

    assign tail = chain[TABLE_DEPTH];

    // result selection and control
    always_comb
    begin
        count_next  = count_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        result_next = '0;
        if (tail.active)
        begin
            done_next = 1'b1;
            busy_next = 1'b0;
            if (!tail.found || ({4'b0, tail.port} >= PORT_LIMIT))
            begin
                result_next.status = ST_DROP_NOROUTE;
            end
            else
            begin
                result_next.status   = ST_FORWARDED;
                result_next.out_port = tail.port;
                result_next.hop_addr = tail.hop_valid ? tail.hop : tail.dest;
                result_next.ttl_out  = tail.ttl - 8'd1;
            end
        end
        else if (accept)
        begin
            case (request.kind)
                KIND_ADD:
                begin
                    done_next = 1'b1;
                    if (count_reg == DEPTH_C)
                    begin
                        result_next.status = ST_FULL;
                    end
                    else
                    begin
                        result_next.status = ST_ADDED;
                        count_next         = count_reg + CW'(1);
                    end
                end
                KIND_LOOKUP:
                begin
                    if (request.ttl_in > 8'd1)
                    begin
                        busy_next = 1'b1;
                    end
                    else
                    begin
                        done_next          = 1'b1;
                        result_next.status = ST_DROP_TTL;
                    end
                end
                default:
                begin
                    done_next = 1'b0;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    // a query leaving the chain only exists during a lookup
    a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tail.active |-> busy_reg)
        else $error("query left the chain while not busy");

    // the table never holds more than its depth
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("route count beyond table depth");

    // a route-added answer goes with one more stored route
    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (result_reg.status == ST_ADDED))
            |-> (count_reg == $past(count_reg) + CW'(1)))
        else $error("added route not counted");

    // a lookup with live ttl holds the block busy and gives no early answer
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        do_lookup |=> (busy_reg && !done_reg))
        else $error("lookup did not enter the chain");

endmodule

>>> tb/route_lookup_checker.sv
// checker for the lpm router: predicts each word's result and compares it with the block
module route_lookup_checker
    import lpm_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16,
    parameter int unsigned PORT_COUNT  = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  request_t    request,
    input  logic        done,
    input  result_t     result,
    output int unsigned failures,
    output int unsigned pending
);
    timeunit 1ns;
    timeprecision 1ps;

    route_t      routes [TABLE_DEPTH];
    int unsigned route_total;
    result_t     answers_due [$];

    // expected answer for one accepted word, appending to the route table on an add
    function automatic result_t forward_word(input request_t w);
        result_t     r;
        logic [5:0]  len;
        logic [31:0] m;
        logic        found;
        int unsigned best;
        logic [5:0]  longest;
        r       = '0;
        found   = 1'b0;
        best    = 0;
        longest = '0;
        if (w.kind == KIND_ADD)
        begin
            if (route_total >= TABLE_DEPTH)
                r.status = ST_FULL;
            else
            begin
                // lengths above 32 are stored as 32
                len = (w.mask_len > 6'd32) ? 6'd32 : w.mask_len;
                routes[route_total] = '{prefix: w.net_prefix, length: len,
                                        hop_valid: w.has_next_hop, hop: w.next_hop_addr,
                                        port: w.egress_port};
                route_total++;
                r.status = ST_ADDED;
            end
        end
        else if (w.ttl_in <= 8'd1)
            r.status = ST_DROP_TTL;
        else
        begin
            // longest match wins, a later route wins a tie
            for (int unsigned i = 0; i < route_total; i++)
            begin
                m = (routes[i].length == 0) ? 32'h0 : ~32'h0 << (32 - routes[i].length);
                if (routes[i].length >= longest
                    && (w.dest_addr & m) == (routes[i].prefix & m))
                begin
                    found   = 1'b1;
                    best    = i;
                    longest = routes[i].length;
                end
            end
            if (!found || routes[best].port >= PORT_COUNT)
                r.status = ST_DROP_NOROUTE;
            else
            begin
                r.status   = ST_FORWARDED;
                r.out_port = routes[best].port;
                r.hop_addr = routes[best].hop_valid ? routes[best].hop : w.dest_addr;
                r.ttl_out  = w.ttl_in - 8'd1;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            route_total = 0;
            answers_due.delete();
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            // a finished word is checked against the oldest prediction
            if (done)
            begin
                if (answers_due.size() == 0)
                begin
                    $write("%0t: result with no word outstanding: ", $time);
                    $display("status %0d port %0d hop %h ttl %0d", result.status,
                             result.out_port, result.hop_addr, result.ttl_out);
                    failures <= failures + 1;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (result.status !== want.status || result.out_port !== want.out_port ||
                        result.hop_addr !== want.hop_addr || result.ttl_out !== want.ttl_out)
                    begin
                        $write("%0t: mismatch: expected status %0d port %0d hop %h ttl %0d, ",
                               $time, want.status, want.out_port, want.hop_addr,
                               want.ttl_out);
                        $display("actual status %0d port %0d hop %h ttl %0d",
                                 result.status, result.out_port, result.hop_addr,
                                 result.ttl_out);
                        failures <= failures + 1;
                    end
                end
            end
            // an accepted word gets its prediction
            if (start && !busy)
                answers_due = {answers_due, forward_word(request)};
            pending <= answers_due.size();
        end
    end

endmodule

>>> tb/testbench.sv
// top of the lpm router testbench: clock, reset, stimulus and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lpm_pkg::*;

    localparam int unsigned TABLE_DEPTH  = 16;
    localparam int unsigned PORT_COUNT   = 8;
    localparam int unsigned RANDOM_WORDS = 1750;
    localparam int unsigned DEFAULT_FROM = RANDOM_WORDS * 3 / 4;
    localparam int unsigned QUIET_FROM   = RANDOM_WORDS * 85 / 100;
    localparam int unsigned SETTLE       = TABLE_DEPTH + 4;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    logic        clk;
    logic        rst_n   = 1'b0;
    logic        start   = 1'b0;
    request_t    request = '0;
    logic        busy;
    logic        done;
    result_t     result;
    int unsigned failures;
    int unsigned pending;
    int unsigned cycles  = 0;

    // routes the stimulus knows about, used to aim datagrams at them
    logic [31:0] held_prefix [TABLE_DEPTH];
    int unsigned held_len [TABLE_DEPTH];
    int unsigned held = 0;

    longest_prefix_match_router #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PORT_COUNT  (PORT_COUNT)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    route_lookup_checker #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PORT_COUNT  (PORT_COUNT)
    ) checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .result   (result),
        .failures (failures),
        .pending  (pending)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // word with every field random, kind included
    function automatic request_t noise_word();
        request_t w;
        w.kind          = 1'($urandom_range(0, 1));
        w.net_prefix    = $urandom();
        w.mask_len      = 6'($urandom_range(0, 63));
        w.has_next_hop  = 1'($urandom_range(0, 1));
        w.next_hop_addr = $urandom();
        w.egress_port   = 3'($urandom_range(0, 7));
        w.dest_addr     = $urandom();
        w.ttl_in        = 8'($urandom_range(0, 255));
        return w;
    endfunction

    function automatic request_t add_word(input logic [31:0] prefix, input logic [5:0] len,
                                          input logic via, input logic [31:0] hop,
                                          input logic [2:0] port);
        request_t w;
        w               = noise_word();
        w.kind          = KIND_ADD;
        w.net_prefix    = prefix;
        w.mask_len      = len;
        w.has_next_hop  = via;
        w.next_hop_addr = hop;
        w.egress_port   = port;
        return w;
    endfunction

    function automatic request_t lookup_word(input logic [31:0] dest, input logic [7:0] ttl);
        request_t w;
        w           = noise_word();
        w.kind      = KIND_LOOKUP;
        w.dest_addr = dest;
        w.ttl_in    = ttl;
        return w;
    endfunction

    // idle burst before a word, none in the quiet tail
    function automatic int unsigned pick_gap(input bit quiet);
        if (quiet || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 18);
    endfunction

    // present one word and hold it until the block takes it
    task automatic send_word(input request_t w, input int unsigned gap);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (w.kind == KIND_ADD && held < TABLE_DEPTH)
        begin
            held_prefix[held] = w.net_prefix;
            held_len[held]    = (w.mask_len > 6'd32) ? 32 : w.mask_len;
            held++;
        end
    endtask

    initial
    begin
        request_t    plan [$];
        request_t    w;
        int unsigned k;
        logic [31:0] m;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words: empty table, low ttl, ties, host bits, saturated lengths
        plan = {plan, lookup_word(32'h0A01_0203, 8'd255)};
        plan = {plan, lookup_word(32'h0A01_0203, 8'd0)};
        plan = {plan, lookup_word(32'h0A01_0203, 8'd1)};
        plan = {plan, add_word(32'h0A00_0000, 6'd8, 1'b1, 32'h0A00_0001, 3'd1)};
        plan = {plan, add_word(32'h0A01_FFFF, 6'd16, 1'b0, 32'h0000_0000, 3'd7)};
        plan = {plan, add_word(32'h0A01_0000, 6'd16, 1'b1, 32'hFFFF_FFFF, 3'd0)};
        plan = {plan, add_word(32'hFFFF_FFFF, 6'd32, 1'b1, 32'h0000_0000, 3'd5)};
        plan = {plan, add_word(32'hC0A8_0100, 6'd40, 1'b0, 32'h0000_0000, 3'd3)};
        plan = {plan, add_word(32'h0000_0000, 6'd63, 1'b1, 32'h0102_0304, 3'd6)};
        plan = {plan, lookup_word(32'h0A01_0203, 8'd2)};
        plan = {plan, lookup_word(32'h0A02_0000, 8'd255)};
        plan = {plan, lookup_word(32'hFFFF_FFFF, 8'd255)};
        plan = {plan, lookup_word(32'hFFFF_FFFE, 8'd255)};
        plan = {plan, lookup_word(32'hC0A8_0100, 8'd100)};
        plan = {plan, lookup_word(32'hC0A8_0101, 8'd100)};
        plan = {plan, lookup_word(32'h0000_0000, 8'd128)};
        plan = {plan, lookup_word(32'h0A01_0203, 8'd1)};
        plan = {plan, lookup_word(32'h0A7F_0000, 8'd254)};
        foreach (plan[j])
            send_word(plan[j], pick_gap(1'b0));

        // random traffic: routes fill the table slowly, the last slot takes a default route
        for (int unsigned i = 0; i < RANDOM_WORDS; i++)
        begin
            w = noise_word();
            if ($urandom_range(0, 11) == 0 && (held != TABLE_DEPTH - 1 || i >= DEFAULT_FROM))
            begin
                w.kind = KIND_ADD;
                if (held == TABLE_DEPTH - 1)
                    w.mask_len = '0;
                else if (held < TABLE_DEPTH - 1)
                begin
                    if ($urandom_range(0, 7) == 0)
                        w.mask_len = 6'($urandom_range(33, 63));
                    else
                        w.mask_len = 6'($urandom_range(1, 32));
                    // nest under or tie with a known route
                    if (held != 0 && $urandom_range(0, 1) == 0)
                    begin
                        k = $urandom_range(0, held - 1);
                        w.net_prefix = held_prefix[k] ^ ($urandom() >> $urandom_range(4, 31));
                        if ($urandom_range(0, 2) == 0)
                            w.mask_len = 6'(held_len[k]);
                    end
                end
                // with the table full the add keeps its noise fields
            end
            else
            begin
                w.kind = KIND_LOOKUP;
                // aim inside a known prefix, sometimes one bit off it
                if (held != 0 && $urandom_range(0, 3) != 0)
                begin
                    k = $urandom_range(0, held - 1);
                    m = (held_len[k] == 0) ? 32'h0 : ~32'h0 << (32 - held_len[k]);
                    w.dest_addr = (held_prefix[k] & m) | ($urandom() & ~m);
                    if (held_len[k] != 0 && $urandom_range(0, 2) == 0)
                        w.dest_addr[32 - $urandom_range(1, held_len[k])] ^= 1'b1;
                end
                if ($urandom_range(0, 9) == 0)
                    w.ttl_in = 8'($urandom_range(0, 1));
            end
            send_word(w, pick_gap(i >= QUIET_FROM));
        end

        // drain and settle
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (failures == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
